// ----- src/dpt_pkg.sv -----
`timescale 1ns / 1ps

package dpt_pkg;

  // register map
  localparam int unsigned CfgAddrWidth = 3;
  localparam logic CFG_DEB_LIMIT = 1'b0;
  localparam logic CFG_HOLD_LIMIT = 1'b1;

  // reset values of the configuration registers, and the ceiling of the held counter
  localparam logic [7:0] DEBOUNCE_RESET = 8'd10;
  localparam logic [15:0] LONG_PRESS_RESET = 16'd100;
  localparam logic [15:0] HELD_MAX = 16'hFFFF;

  // one result item
  typedef struct packed {
    logic switch_on;
    logic state_changed;
    logic partner_off;
  } result_t;

endpackage

// ----- src/debounced_press_toggle_top.sv -----
`timescale 1ns / 1ps

// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+------------------------------------
// input     | in        | in_valid / in_stall  | raw_level, forced_off
// output    | out       | out_valid / out_stall| switch_on, state_changed, partner_off
// config    | in/out    | apb psel/penable     | paddr, pwdata, prdata, pready
//
// one request per cycle while in_stall is low: the state update is one pass of logic at
// the accept edge, and its result is registered in the output or the skid register.
// a two-entry output buffer (output register plus skid register) lets a request
// be accepted while a result waits; in_stall rises only when both entries are full.
// rst is synchronous and resets the debounce state, the buffer and the registers.

module debounced_press_toggle_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 raw_level,
  input  logic                                 forced_off,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 switch_on,
  output logic                                 state_changed,
  output logic                                 partner_off,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [dpt_pkg::CfgAddrWidth-1:0]     paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  logic [7:0]  deb_limit;
  logic [15:0] hold_limit;

  logic [7:0]  integrator, integrator_next;
  logic [15:0] held_ticks, held_ticks_next;
  logic        released_flag, released_flag_next;
  logic        toggle_armed, toggle_armed_next;
  logic        target_on, target_on_next;
  logic        on_state, on_state_next;

  dpt_pkg::result_t result_next;
  dpt_pkg::result_t out_data;
  dpt_pkg::result_t skid_data;
  logic             skid_valid;

  logic        in_accept;
  logic        out_pop;
  logic        cfg_write;
  logic [7:0]  integ_step;
  logic [15:0] held_inc;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !skid_valid;
  assign out_pop   = out_valid && !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      deb_limit  <= dpt_pkg::DEBOUNCE_RESET;
      hold_limit <= dpt_pkg::LONG_PRESS_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        dpt_pkg::CFG_DEB_LIMIT:  deb_limit  <= pwdata[7:0];
        dpt_pkg::CFG_HOLD_LIMIT: hold_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[2])
      dpt_pkg::CFG_DEB_LIMIT:  prdata = {24'd0, deb_limit};
      dpt_pkg::CFG_HOLD_LIMIT: prdata = {16'd0, hold_limit};
      default:                 prdata = 32'd0;
    endcase
  end

  // debounce and press update for one tick
  always_comb begin
    released_flag_next = released_flag;
    toggle_armed_next  = toggle_armed;
    target_on_next     = target_on;
    held_ticks_next    = held_ticks;
    on_state_next      = forced_off ? 1'b0 : on_state;
    result_next.partner_off = 1'b0;

    // saturating integrator
    integ_step = integrator;
    if (!raw_level) begin
      if (integrator != 8'd0) integ_step = integrator - 8'd1;
    end else if (integrator < deb_limit) begin
      integ_step = integrator + 8'd1;
    end
    integrator_next = integ_step;

    held_inc = (held_ticks != dpt_pkg::HELD_MAX) ? held_ticks + 16'd1 : held_ticks;

    priority if (integ_step == 8'd0) begin
      // switch held
      held_ticks_next = held_inc;
      if (held_inc >= hold_limit) begin
        held_ticks_next         = hold_limit;
        result_next.partner_off = 1'b1;
        toggle_armed_next       = 1'b0;
        if (!on_state_next) begin
          target_on_next = 1'b1;
          on_state_next  = 1'b1;
        end
      end else if (on_state_next) begin
        if (released_flag) begin
          toggle_armed_next = 1'b1;
          target_on_next    = 1'b0;
        end
      end else begin
        target_on_next    = 1'b1;
        toggle_armed_next = 1'b1;
      end
      released_flag_next = 1'b0;
    end else if (integ_step >= deb_limit) begin
      // debounced release
      if (toggle_armed) on_state_next = target_on;
      target_on_next     = 1'b0;
      toggle_armed_next  = 1'b0;
      released_flag_next = 1'b1;
      held_ticks_next    = 16'd0;
      integrator_next    = deb_limit;
    end else begin
    end

    result_next.switch_on     = on_state_next;
    result_next.state_changed = on_state_next != on_state;
  end

  // tick state
  always_ff @(posedge clk) begin
    if (rst) begin
      integrator    <= 8'd0;
      held_ticks    <= 16'd0;
      released_flag <= 1'b1;
      toggle_armed  <= 1'b0;
      target_on     <= 1'b0;
      on_state      <= 1'b0;
    end else if (in_accept) begin
      integrator    <= integrator_next;
      held_ticks    <= held_ticks_next;
      released_flag <= released_flag_next;
      toggle_armed  <= toggle_armed_next;
      target_on     <= target_on_next;
      on_state      <= on_state_next;
    end
  end

  // output register and skid register valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_pop) skid_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
      if (out_valid && !out_pop) skid_valid <= 1'b1;
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_pop) out_data <= skid_data;
    end else if (in_accept) begin
      if (!out_valid || out_pop) out_data <= result_next;
      else skid_data <= result_next;
    end
  end

  assign switch_on     = out_data.switch_on;
  assign state_changed = out_data.state_changed;
  assign partner_off   = out_data.partner_off;

  // the skid entry is only ever filled behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while the output register is empty");

  // a long press always leaves the switch on
  a_long_press_on: assert property (@(posedge clk) disable iff (rst)
    in_accept && result_next.partner_off |-> result_next.switch_on)
    else $error("long press result with the switch off");

  // an accepted request always lands in the output buffer, with out_valid high next cycle
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted request did not reach the output buffer");

  // a full buffer that is not drained stays full
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_stall |=> skid_valid && $stable(out_data))
    else $error("full buffer changed while the output was stalled");

endmodule
